[sv/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants of the double-ended queue: sizes, operation and
// status codes, controller states and the controller-to-datapath command
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = IDX_W + 1;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [SUM_W-1:0]      sum_type;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_FORM
   } state_type;

   typedef struct packed {
      logic capture;
      logic access;
      logic load_out;
   } cmd_type;

endpackage

[sv/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// sequencer of the double-ended queue: takes an item, runs the storage access,
// then loads the result register once it is free or being drained
// ----------------------------------------------------------------------------
module dq_ctrl
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            state_in = S_FORM;
         end
         S_FORM: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
         end
         S_FORM: begin
            cmd.load_out = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/dq_datapath.sv]
// ----------------------------------------------------------------------------
// dq_datapath
// ring buffer storage with front index and fill count, operation decode,
// status generation and the result register
// ----------------------------------------------------------------------------
module dq_datapath
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [2:0]  operation,
   input  logic [31:0] data_in,
   output logic [39:0] result  // data_out, status, is_empty, entry_count
);

   word_type   mem [DEPTH];
   logic [2:0] op_ff;
   word_type   din_ff;
   word_type   rd_ff;
   idx_type    front_ff, front_in;
   cnt_type    count_ff, count_in;
   status_type status_ff, status_in;
   logic       read_ok_ff;
   logic [39:0] result_ff;

   logic    full, empty, is_push, is_read, use_front;
   logic    do_write, do_read;
   idx_type front_dec, front_inc, tail_idx, back_idx, addr;
   sum_type tail_sum, back_sum;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign is_push = op_ff == OP_PUSH_FRONT || op_ff == OP_PUSH_BACK;
   assign is_read = op_ff == OP_POP_FRONT || op_ff == OP_POP_BACK ||
                    op_ff == OP_PEEK_FRONT || op_ff == OP_PEEK_BACK;
   assign use_front = op_ff == OP_POP_FRONT || op_ff == OP_PEEK_FRONT;

   // ring index arithmetic, sums stay below twice the depth
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_sum  = tail_sum - 1'b1;
   assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(DEPTH)) : IDX_W'(tail_sum);
   assign back_idx  = (back_sum >= SUM_W'(DEPTH)) ?
                      IDX_W'(back_sum - SUM_W'(DEPTH)) : IDX_W'(back_sum);

   assign do_write = cmd.access && is_push && !full;
   assign do_read  = cmd.access && is_read && !empty;

   always_comb begin
      priority case (1'b1)
         op_ff == OP_PUSH_FRONT: addr = front_dec;
         op_ff == OP_PUSH_BACK:  addr = tail_idx;
         use_front:              addr = front_ff;
         default:                addr = back_idx;
      endcase
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      if (is_push && full) begin
         status_in = ST_FULL;
      end else if (is_read && empty) begin
         status_in = ST_EMPTY;
      end else if (is_push) begin
         count_in = count_ff + 1'b1;
         if (op_ff == OP_PUSH_FRONT) begin
            front_in = front_dec;
         end
      end else if (op_ff == OP_POP_FRONT) begin
         count_in = count_ff - 1'b1;
         front_in = front_inc;
      end else if (op_ff == OP_POP_BACK) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[addr] <= din_ff;
      end
      if (do_read) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.access) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= operation;
         din_ff <= word_type'(data_in);
      end
      if (cmd.access) begin
         status_ff  <= status_in;
         read_ok_ff <= is_read && !empty;
      end
      if (cmd.load_out) begin
         result_ff <= {count_ff, empty, status_ff,
                       read_ok_ff ? 32'(rd_ff) : 32'd0};
      end
   end

   assign result = result_ff;

endmodule

[sv/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of 16 words in a ring buffer with push, pop and peek at
// either end, one result item for every request item
// ----------------------------------------------------------------------------
// Each request item passes through capture, one storage access (a write
// for a push, a registered read for a pop or peek) and loading of the result
// register, which waits while a held result is not drained. A new request is
// taken while the previous result still waits in the result register.
// Pops and peeks on an empty deque report an empty error, pushes into a full
// deque report a full error and drop the word; codes 6 and 7 do nothing.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data_in
   input  logic [2:0]  req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // data_out, status, is_empty, entry_count
);

   cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .operation (req_tuser),
      .data_in   (req_tdata),
      .result    (rsp_tdata)
   );

endmodule

[tb/double_ended_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the 16-entry deque. A queue of operations is filled
// with a directed opening and then random bursts that lean toward pushes or
// pops, so that the full and empty edges come up again and again. The driver
// and the monitor are clocked processes. Each accepted request is run through
// a shadow deque, and every result item is compared field by field with the
// oldest prediction. Both sides idle at random over two phases, then not at
// all; the receiver stalls once for a long stretch, and the sender once
// waits for everything to drain.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   import dq_pkg::*;

   localparam logic [2:0] OP_NOP_LOW  = 3'd6;
   localparam logic [2:0] OP_NOP_HIGH = 3'd7;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_LEN    = 175;
   localparam int STALL_AT     = 380;
   localparam int STALL_CYCLES = 60;
   localparam int DRAIN_AT     = 450;

   typedef struct packed {
      logic [2:0] op;
      word_type   word;
   } deque_request_type;

   typedef struct packed {
      cnt_type    count;
      logic       is_empty;
      status_type status;
      word_type   data_out;
   } deque_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // data_in
   logic [2:0]  req_tuser = '0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // data_out, status, is_empty, entry_count

   deque_request_type ops_to_send[$];
   deque_reply_type   replies_due[$];
   word_type          shadow_words[DEPTH];
   idx_type           shadow_front = '0;
   cnt_type           shadow_fill = '0;
   int                accepted_count = 0;
   int                stall_left = 0;
   bit                stall_done = 1'b0;
   bit                failed = 1'b0;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic deque_reply_type apply_to_shadow(logic [2:0] op, word_type word);
      deque_reply_type reply;
      idx_type         back_pos;
      reply = '0;
      reply.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_fill == cnt_type'(DEPTH)) begin
               reply.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               shadow_front = idx_type'((int'(shadow_front) + DEPTH - 1) % DEPTH);
               shadow_words[shadow_front] = word;
               shadow_fill++;
            end else begin
               shadow_words[(int'(shadow_front) + int'(shadow_fill)) % DEPTH] = word;
               shadow_fill++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (shadow_fill == '0) begin
               reply.status = ST_EMPTY;
            end else begin
               back_pos = idx_type'((int'(shadow_front) + int'(shadow_fill) - 1) % DEPTH);
               if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                  reply.data_out = shadow_words[shadow_front];
               else
                  reply.data_out = shadow_words[back_pos];
               if (op == OP_POP_FRONT) begin
                  shadow_front = idx_type'((int'(shadow_front) + 1) % DEPTH);
                  shadow_fill--;
               end else if (op == OP_POP_BACK) begin
                  shadow_fill--;
               end
            end
         end
         default: ;
      endcase
      reply.is_empty = (shadow_fill == '0);
      reply.count    = shadow_fill;
      return reply;
   endfunction

   function automatic int idle_percent(bit receiver_side);
      if (accepted_count < PHASE_LEN)
         return receiver_side ? 76 : 13;
      else if (accepted_count < 2 * PHASE_LEN)
         return receiver_side ? 13 : 76;
      return 0;
   endfunction

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : drive_requests
      deque_request_type next_item;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_to_shadow(req_tuser, req_tdata));
            accepted_count++;
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (ops_to_send.size() != 0
                      && !(accepted_count == DRAIN_AT && replies_due.size() != 0)
                      && $urandom_range(0, 99) >= idle_percent(1'b0)) begin
            next_item = ops_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_item.op;
            req_tdata  <= next_item.word;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_replies
      deque_reply_type got;
      deque_reply_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (replies_due.size() == 0) begin
               $error("result item with no prediction pending: %h", rsp_tdata);
               failed = 1'b1;
            end else begin
               want = replies_due.pop_front();
               if (got.data_out !== want.data_out) begin
                  $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                  failed = 1'b1;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  failed = 1'b1;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
                  failed = 1'b1;
               end
               if (got.count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, got.count);
                  failed = 1'b1;
               end
            end
         end
         if (!stall_done && accepted_count >= STALL_AT) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_percent(1'b1));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("double_ended_queue: mismatch");
      $finish;
   end

   initial begin : stimulus
      int bias;
      int roll;
      logic [2:0] op;
      // empty deque, no-ops
      ops_to_send.push_back('{OP_POP_FRONT, 32'h1234_5678});
      ops_to_send.push_back('{OP_PEEK_BACK, 32'h0});
      ops_to_send.push_back('{OP_NOP_LOW, 32'hFFFF_FFFF});
      ops_to_send.push_back('{OP_NOP_HIGH, 32'h0});
      // fill to capacity from both ends
      for (int i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0: ops_to_send.push_back('{OP_PUSH_BACK, 32'h0});
            1: ops_to_send.push_back('{OP_PUSH_FRONT, 32'hFFFF_FFFF});
            2: ops_to_send.push_back('{OP_PUSH_FRONT, 32'hAAAA_5555 ^ i});
            default: ops_to_send.push_back('{OP_PUSH_BACK, 32'h5555_AAAA ^ i});
         endcase
      end
      ops_to_send.push_back('{OP_PUSH_FRONT, 32'hDEAD_BEEF});
      ops_to_send.push_back('{OP_PUSH_BACK, 32'hCAFE_F00D});
      ops_to_send.push_back('{OP_PEEK_FRONT, 32'h0});
      ops_to_send.push_back('{OP_PEEK_BACK, 32'h0});
      ops_to_send.push_back('{OP_POP_FRONT, 32'h0});
      ops_to_send.push_back('{OP_POP_BACK, 32'h0});
      // random bursts leaning toward pushes, pops or neither
      bias = 1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 0)
            bias = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         if (roll < 4)
            op = $urandom_range(0, 1) ? OP_NOP_HIGH : OP_NOP_LOW;
         else if (roll < (bias == 0 ? 74 : bias == 1 ? 34 : 52))
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else
            op = 3'($urandom_range(OP_POP_FRONT, OP_PEEK_BACK));
         ops_to_send.push_back('{op, random_word()});
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (ops_to_send.size() != 0 || req_tvalid || replies_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed && replies_due.size() == 0) begin
         $display("double_ended_queue: match");
      end else begin
         $display("double_ended_queue: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
tb/double_ended_queue_tb.sv
